/* design/cisof_pkg.sv */
package cisof_pkg;

   localparam int unsigned VOCAB_SIZE  = 12;
   localparam int unsigned MAX_PATTERN = 16;

   localparam int unsigned PITCH_W    = 7;
   localparam int unsigned LEN_W      = 5;
   localparam int unsigned STEP_W     = 4;
   localparam int unsigned IVL_W      = 60;
   localparam int unsigned COUNT_W    = 24;
   localparam int unsigned SET_W      = 12;
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 40;
   localparam int unsigned CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVALS = 1'd1;

   localparam logic [LEN_W-1:0]   LEN_MIN   = 5'd2;
   localparam logic [LEN_W-1:0]   LEN_RESET = 5'd2;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef struct packed {
      logic             load_init;
      logic             advance;
      logic [LEN_W-1:0] len;
   } cell_ctrl_type;

endpackage

/* design/cisof_interval.sv */
module cisof_interval #(
   parameter int unsigned VocabSize = cisof_pkg::VOCAB_SIZE
) (
   input  logic [cisof_pkg::PITCH_W-1:0] pitch,
   input  logic [VocabSize-1:0]          prev_classes,
   input  logic [VocabSize-1:0]          cur_classes,
   output logic [VocabSize-1:0]          pitch_onehot,
   output logic [VocabSize-1:0]          interval_set
);

   localparam int unsigned ClsW    = $clog2(VocabSize);
   localparam int unsigned Pitches = 2 ** cisof_pkg::PITCH_W;

   logic [Pitches-1:0][ClsW-1:0]          class_lut;
   logic [VocabSize-1:0][VocabSize-1:0]   term;

   for (genvar p = 0; p < Pitches; p++) begin : g_lut
      localparam int unsigned Cls = p % VocabSize;
      assign class_lut[p] = ClsW'(Cls);
   end

   assign pitch_onehot = VocabSize'(1) << class_lut[pitch];

   for (genvar k = 0; k < VocabSize; k++) begin : g_set
      for (genvar a = 0; a < VocabSize; a++) begin : g_term
         localparam int unsigned Idx = (k + a) % VocabSize;
         assign term[k][a] = prev_classes[a] & cur_classes[Idx];
      end
      assign interval_set[k] = |term[k];
   end

endmodule

/* design/cisof_cell.sv */
module cisof_cell #(
   parameter int unsigned VocabSize = cisof_pkg::VOCAB_SIZE,
   parameter int unsigned Index     = 0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  cisof_pkg::cell_ctrl_type        ctrl,
   input  logic [VocabSize-1:0]            interval_set,
   input  logic [cisof_pkg::STEP_W-1:0]    step_code,
   input  logic                            shift_in,
   output logic                            bit_q,
   output logic                            bit_next
);

   localparam logic [cisof_pkg::LEN_W-1:0] Pos     = cisof_pkg::LEN_W'(Index);
   localparam logic [cisof_pkg::LEN_W-1:0] PosNext = cisof_pkg::LEN_W'(Index + 1);
   localparam int unsigned CodeSpan = 2 ** cisof_pkg::STEP_W;

   logic [CodeSpan-1:0]           set_ext;
   logic [cisof_pkg::STEP_W:0]    code_ext;
   logic                          in_len;
   logic                          is_step;
   logic                          miss;
   logic                          bit_ff;
   logic                          bit_in;

   assign set_ext  = CodeSpan'(interval_set);
   assign code_ext = {1'b0, step_code};
   assign in_len   = Pos < ctrl.len;
   assign is_step  = PosNext < ctrl.len;
   assign miss     = (code_ext >= (cisof_pkg::STEP_W + 1)'(VocabSize)) || !set_ext[step_code];
   assign bit_next = in_len & (shift_in | (is_step & miss));

   always_comb begin
      bit_in = bit_ff;
      if (ctrl.load_init) begin
         bit_in = is_step;
      end else if (ctrl.advance) begin
         bit_in = bit_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= (Index == 0);
      end else begin
         bit_ff <= bit_in;
      end
   end

   assign bit_q = bit_ff;

endmodule

/* design/chord_interval_shift_or_filter_core.sv */
// Channel   Direction  Ports                       Payload
// req       in         req_tvalid/tready/tdata     pitch; tlast chord_end; tuser song_start
// rsp       out        rsp_tvalid/tready/tdata     start_chord, interval_set; tuser candidate
// csr       in         csr_valid/ready/index/wdata pattern_length, pattern_intervals
//
// One note per cycle while req_tready is high; a chord-end note's result, if any, is registered
// in the output register, or in the skid register while the output stalls. The match vector is
// a row of one-bit cells, all updated in the chord-end cycle. req_tready drops only while
// the skid register is full. csr_ready is always high.
// Synchronous reset restores the configuration defaults and clears the song state.
module chord_interval_shift_or_filter_core #(
   parameter int unsigned VocabSize  = cisof_pkg::VOCAB_SIZE,
   parameter int unsigned MaxPattern = cisof_pkg::MAX_PATTERN
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [cisof_pkg::REQ_DATA_W-1:0]     req_tdata,  // [6:0] pitch
   input  logic                                 req_tlast,  // chord_end
   input  logic                                 req_tuser,  // song_start
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [cisof_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // [23:0] start_chord, [35:24] interval_set
   output logic                                 rsp_tuser,  // candidate
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cisof_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cisof_pkg::IVL_W-1:0]          csr_wdata
);

   localparam int unsigned StepW  = cisof_pkg::STEP_W;
   localparam int unsigned LenW   = cisof_pkg::LEN_W;
   localparam int unsigned CountW = cisof_pkg::COUNT_W;
   localparam int unsigned SetW   = cisof_pkg::SET_W;
   localparam int unsigned IvlW   = StepW * (MaxPattern - 1);
   localparam int unsigned SelW   = $clog2(MaxPattern);
   localparam int unsigned RspPad = cisof_pkg::RSP_DATA_W - CountW - SetW;

   logic [LenW-1:0]          length_ff;
   logic [IvlW-1:0]          intervals_ff;
   logic [VocabSize-1:0]     prev_ff;
   logic [VocabSize-1:0]     prev_in;
   logic [VocabSize-1:0]     cur_ff;
   logic [VocabSize-1:0]     cur_in;
   logic [CountW-1:0]        count_ff;
   logic [CountW-1:0]        count_in;
   logic [CountW-1:0]        count_base;
   logic [VocabSize-1:0]     pitch_onehot;
   logic [VocabSize-1:0]     cur_base;
   logic [VocabSize-1:0]     interval_set;
   logic [LenW-1:0]          len_eff;
   logic [SelW-1:0]          cand_sel;
   logic [MaxPattern-1:0]    vec_q;
   logic [MaxPattern-1:0]    vec_next;
   logic [MaxPattern-1:0]    shift_chain;
   logic                     req_accept;
   logic                     res_fire;
   logic                     rsp_take;
   logic                     res_cand;
   logic [CountW-1:0]        res_start;
   logic [SetW-1:0]          res_set;
   cisof_pkg::cell_ctrl_type ctrl;

   logic                     out_valid_ff;
   logic                     out_cand_ff;
   logic [CountW-1:0]        out_start_ff;
   logic [SetW-1:0]          out_set_ff;
   logic                     skid_valid_ff;
   logic                     skid_cand_ff;
   logic [CountW-1:0]        skid_start_ff;
   logic [SetW-1:0]          skid_set_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= cisof_pkg::LEN_RESET;
         intervals_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            cisof_pkg::CSR_LENGTH:    length_ff    <= csr_wdata[LenW-1:0];
            cisof_pkg::CSR_INTERVALS: intervals_ff <= csr_wdata[IvlW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      len_eff = length_ff;
      if (length_ff < cisof_pkg::LEN_MIN) begin
         len_eff = cisof_pkg::LEN_MIN;
      end else if (length_ff > LenW'(MaxPattern)) begin
         len_eff = LenW'(MaxPattern);
      end
   end

   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_take   = rsp_tvalid && rsp_tready;

   cisof_interval #(
      .VocabSize(VocabSize)
   ) u_interval (
      .pitch        (req_tdata[cisof_pkg::PITCH_W-1:0]),
      .prev_classes (prev_ff),
      .cur_classes  (cur_in),
      .pitch_onehot (pitch_onehot),
      .interval_set (interval_set)
   );

   assign cur_base   = req_tuser ? '0 : cur_ff;
   assign count_base = req_tuser ? '0 : count_ff;
   assign cur_in     = cur_base | pitch_onehot;
   assign res_fire   = req_accept && req_tlast && !req_tuser && (count_ff != '0);

   always_comb begin
      prev_in  = prev_ff;
      count_in = count_ff;
      if (req_accept) begin
         prev_in  = req_tuser ? '0 : prev_ff;
         count_in = count_base;
         if (req_tlast) begin
            prev_in = cur_in;
            if (count_base != cisof_pkg::COUNT_MAX) begin
               count_in = count_base + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         cur_ff   <= '0;
         count_ff <= '0;
      end else begin
         prev_ff  <= prev_in;
         count_ff <= count_in;
         if (req_accept) begin
            cur_ff <= req_tlast ? '0 : cur_in;
         end
      end
   end

   assign ctrl.load_init = req_accept && req_tuser;
   assign ctrl.advance   = res_fire;
   assign ctrl.len       = len_eff;

   for (genvar i = 0; i < MaxPattern; i++) begin : g_cell
      logic [StepW-1:0] code;
      if (i == 0) begin : g_head
         assign shift_chain[i] = 1'b0;
      end else begin : g_link
         assign shift_chain[i] = vec_q[i-1];
      end
      if (i < MaxPattern - 1) begin : g_code
         assign code = intervals_ff[StepW*i +: StepW];
      end else begin : g_nocode
         assign code = '0;
      end
      cisof_cell #(
         .VocabSize (VocabSize),
         .Index     (i)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .interval_set (interval_set),
         .step_code    (code),
         .shift_in     (shift_chain[i]),
         .bit_q        (vec_q[i]),
         .bit_next     (vec_next[i])
      );
   end

   assign cand_sel  = SelW'(len_eff - LenW'(2));
   assign res_cand  = !vec_next[cand_sel];
   assign res_start = res_cand ? (count_ff - CountW'(len_eff - LenW'(1))) : '0;
   assign res_set   = SetW'(interval_set);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_take) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (res_fire) begin
         if (!out_valid_ff || rsp_take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take) begin
            out_cand_ff  <= skid_cand_ff;
            out_start_ff <= skid_start_ff;
            out_set_ff   <= skid_set_ff;
         end
      end else if (res_fire) begin
         if (!out_valid_ff || rsp_take) begin
            out_cand_ff  <= res_cand;
            out_start_ff <= res_start;
            out_set_ff   <= res_set;
         end else begin
            skid_cand_ff  <= res_cand;
            skid_start_ff <= res_start;
            skid_set_ff   <= res_set;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_cand_ff;
   assign rsp_tdata  = {RspPad'(0), out_set_ff, out_start_ff};

   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while output register empty");

   assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_tvalid && !rsp_tready))
      else $error("skid register filled without an output stall");

   assert property (@(posedge clock) disable iff (reset)
      (req_accept && !req_tuser) |=> (count_ff >= $past(count_ff)))
      else $error("chord counter went backward within a song");

endmodule

/* dv/chord_interval_shift_or_filter_core_test.sv */
module chord_interval_shift_or_filter_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic                          candidate;
      logic [cisof_pkg::COUNT_W-1:0] start_chord;
      logic [cisof_pkg::SET_W-1:0]   interval_set;
   } chord_result_type;

   typedef struct packed {
      logic [cisof_pkg::PITCH_W-1:0] pitch;
      logic                          chord_end;
      logic                          song_start;
      logic                          typed;
      chord_result_type              result;
   } song_note_type;

   logic clock = 1'b0;
   logic reset;

   logic                             req_tvalid;
   logic                             req_tready;
   logic [cisof_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                             req_tlast;
   logic                             req_tuser;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [cisof_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                             rsp_tuser;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [cisof_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [cisof_pkg::IVL_W-1:0]      csr_wdata;

   logic [cisof_pkg::LEN_W-1:0]       cfg_length;
   logic [cisof_pkg::IVL_W-1:0]       cfg_steps;
   logic [cisof_pkg::SET_W-1:0]       prior_chord;
   logic [cisof_pkg::SET_W-1:0]       open_chord;
   logic [cisof_pkg::MAX_PATTERN-1:0] shift_vec;
   logic [cisof_pkg::COUNT_W-1:0]     chord_index;

   chord_result_type chord_results_due[$];
   song_note_type    directed_notes[16];
   int unsigned      errors = 0;
   int unsigned      cycle_count = 0;
   int unsigned      last_class = 0;
   bit               steady = 1'b0;

   chord_interval_shift_or_filter_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL chord_interval_shift_or_filter_core");
         $finish;
      end
   end

   function automatic int unsigned clamp_length();
      int unsigned m;
      m = 32'(cfg_length);
      if (m < 2) m = 2;
      if (m > cisof_pkg::MAX_PATTERN) m = cisof_pkg::MAX_PATTERN;
      return m;
   endfunction

   function automatic void restart_song();
      prior_chord = '0;
      open_chord  = '0;
      chord_index = '0;
      shift_vec   = cisof_pkg::MAX_PATTERN'((32'd1 << (clamp_length() - 1)) - 1);
   endfunction

   function automatic logic [cisof_pkg::SET_W-1:0] interval_span(
         input logic [cisof_pkg::SET_W-1:0] from_set,
         input logic [cisof_pkg::SET_W-1:0] to_set);
      logic [2*cisof_pkg::SET_W-1:0] twice;
      logic [cisof_pkg::SET_W-1:0]   span;
      twice = {to_set, to_set};
      span  = '0;
      for (int a = 0; a < cisof_pkg::VOCAB_SIZE; a++) begin
         if (from_set[a]) span |= cisof_pkg::SET_W'(twice >> a);
      end
      return span;
   endfunction

   function automatic bit advance_song(input logic [cisof_pkg::PITCH_W-1:0] pitch,
                                       input logic chord_end, input logic song_start,
                                       output chord_result_type res);
      int unsigned                       m;
      int unsigned                       pc;
      logic [cisof_pkg::SET_W-1:0]       span;
      logic [cisof_pkg::MAX_PATTERN-1:0] column;
      logic [cisof_pkg::MAX_PATTERN:0]   grown;
      logic [cisof_pkg::MAX_PATTERN:0]   keep;
      logic [cisof_pkg::STEP_W-1:0]      code;
      res = '0;
      if (song_start) restart_song();
      pc = pitch % cisof_pkg::VOCAB_SIZE;
      open_chord[pc] = 1'b1;
      if (!chord_end) return 1'b0;
      if (chord_index == '0) begin
         prior_chord = open_chord;
         open_chord  = '0;
         chord_index = cisof_pkg::COUNT_W'(1);
         return 1'b0;
      end
      m      = clamp_length();
      span   = interval_span(prior_chord, open_chord);
      column = '0;
      for (int unsigned i = 0; i + 1 < m; i++) begin
         code = cfg_steps[cisof_pkg::STEP_W*i +: cisof_pkg::STEP_W];
         if (code >= cisof_pkg::VOCAB_SIZE || !span[code]) column[i] = 1'b1;
      end
      keep      = {(cisof_pkg::MAX_PATTERN+1){1'b1}} >> (cisof_pkg::MAX_PATTERN + 1 - m);
      grown     = (({1'b0, shift_vec} << 1) | {1'b0, column}) & keep;
      shift_vec = grown[cisof_pkg::MAX_PATTERN-1:0];
      res.candidate    = ~shift_vec[m-2];
      res.start_chord  = res.candidate ? chord_index - cisof_pkg::COUNT_W'(m - 1) : '0;
      res.interval_set = span;
      prior_chord = open_chord;
      open_chord  = '0;
      if (chord_index != cisof_pkg::COUNT_MAX) chord_index++;
      return 1'b1;
   endfunction

   function automatic logic [cisof_pkg::IVL_W-1:0] random_word();
      return cisof_pkg::IVL_W'({$urandom(), $urandom()});
   endfunction

   function automatic logic [cisof_pkg::IVL_W-1:0] random_steps();
      logic [cisof_pkg::IVL_W-1:0] w;
      w = '0;
      for (int i = 0; i < cisof_pkg::MAX_PATTERN - 1; i++) begin
         w[cisof_pkg::STEP_W*i +: cisof_pkg::STEP_W] = cisof_pkg::STEP_W'($urandom_range(0, 11));
      end
      return w;
   endfunction

   task automatic push_note(input logic [cisof_pkg::PITCH_W-1:0] pitch, input logic chord_end,
                            input logic song_start, input logic typed,
                            input chord_result_type typed_res);
      int unsigned      gap;
      bit               made;
      chord_result_type res;
      gap = steady ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= cisof_pkg::REQ_DATA_W'(pitch);
      req_tlast  <= chord_end;
      req_tuser  <= song_start;
      do @(posedge clock); while (!req_tready);
      made = advance_song(pitch, chord_end, song_start, res);
      if (typed) chord_results_due.push_back(typed_res);
      else if (made) chord_results_due.push_back(res);
      last_class = pitch % cisof_pkg::VOCAB_SIZE;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (chord_results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [cisof_pkg::CSR_IDX_W-1:0] idx,
                            input logic [cisof_pkg::IVL_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == cisof_pkg::CSR_LENGTH) cfg_length = value[cisof_pkg::LEN_W-1:0];
      else cfg_steps = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic play_phase(input int unsigned budget, input bit continue_song);
      int unsigned                   sent;
      int unsigned                   chords;
      int unsigned                   notes;
      int unsigned                   tune_pos;
      int unsigned                   step;
      int unsigned                   m;
      int unsigned                   code;
      int unsigned                   tune;
      bit                            tuned;
      bit                            fresh;
      logic [cisof_pkg::PITCH_W-1:0] p;
      sent  = 0;
      fresh = !continue_song;
      m     = clamp_length();
      while (sent < budget) begin
         chords = $urandom_range(2, 30);
         tuned  = ($urandom_range(0, 3) != 0);
         step   = 0;
         tune   = fresh ? $urandom_range(0, 11) : last_class;
         for (int unsigned c = 0; c < chords && sent < budget; c++) begin
            if (c != 0 || !fresh) begin
               code = 32'(cfg_steps[cisof_pkg::STEP_W*step +: cisof_pkg::STEP_W]);
               // break the tune now and then
               if (code >= cisof_pkg::VOCAB_SIZE || $urandom_range(0, 7) == 0) begin
                  tune = $urandom_range(0, 11);
               end else begin
                  tune = (tune + code) % cisof_pkg::VOCAB_SIZE;
               end
               step = (step + 1) % (m - 1);
            end
            notes    = $urandom_range(1, 3);
            tune_pos = $urandom_range(0, notes - 1);
            for (int unsigned n = 0; n < notes; n++) begin
               if (tuned && n == tune_pos) begin
                  p = cisof_pkg::PITCH_W'(tune + 12 * $urandom_range(0, 9));
               end else begin
                  p = cisof_pkg::PITCH_W'($urandom_range(0, 127));
               end
               push_note(p, n == notes - 1, fresh && c == 0 && n == 0, 1'b0, '0);
               sent++;
            end
         end
         fresh = 1'b1;
      end
   endtask

   task automatic receive_results();
      int unsigned      stall;
      chord_result_type want;
      chord_result_type got;
      forever begin
         stall = steady ? 0 : $urandom_range(0, 9);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got.candidate    = rsp_tuser;
         got.start_chord  = rsp_tdata[cisof_pkg::COUNT_W-1:0];
         got.interval_set = rsp_tdata[cisof_pkg::COUNT_W +: cisof_pkg::SET_W];
         if (chord_results_due.size() == 0) begin
            $display("%0t: unexpected transaction candidate=%0b start_chord=%0d interval_set=%03h",
                     $time, got.candidate, got.start_chord, got.interval_set);
            errors++;
         end else begin
            want = chord_results_due.pop_front();
            if (got.candidate !== want.candidate) begin
               $display("%0t: candidate expected %0b actual %0b",
                        $time, want.candidate, got.candidate);
               errors++;
            end
            if (got.start_chord !== want.start_chord) begin
               $display("%0t: start_chord expected %0d actual %0d",
                        $time, want.start_chord, got.start_chord);
               errors++;
            end
            if (got.interval_set !== want.interval_set) begin
               $display("%0t: interval_set expected %03h actual %03h",
                        $time, want.interval_set, got.interval_set);
               errors++;
            end
         end
      end
   endtask

   initial begin
      logic [cisof_pkg::IVL_W-1:0] len_word;
      logic [cisof_pkg::IVL_W-1:0] steps_word;
      bit                          cont;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      req_tuser  <= 1'b0;
      rsp_tready <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      cfg_length = cisof_pkg::LEN_RESET;
      cfg_steps  = '0;
      restart_song();

      directed_notes = '{
         '{7'd0,   1'b1, 1'b1, 1'b0, '0},
         '{7'd127, 1'b1, 1'b0, 1'b1, '{1'b0, 24'd0, 12'h080}},
         '{7'd7,   1'b1, 1'b0, 1'b1, '{1'b1, 24'd1, 12'h001}},
         '{7'd12,  1'b0, 1'b0, 1'b0, '0},
         '{7'd126, 1'b0, 1'b0, 1'b0, '0},
         '{7'd65,  1'b1, 1'b0, 1'b0, '0},
         '{7'd3,   1'b0, 1'b1, 1'b0, '0},
         '{7'd96,  1'b1, 1'b0, 1'b0, '0},
         '{7'd15,  1'b1, 1'b0, 1'b1, '{1'b1, 24'd0, 12'h009}},
         '{7'd100, 1'b0, 1'b1, 1'b0, '0},
         '{7'd1,   1'b0, 1'b1, 1'b0, '0},
         '{7'd1,   1'b1, 1'b1, 1'b0, '0},
         '{7'd127, 1'b1, 1'b0, 1'b0, '0},
         '{7'd0,   1'b1, 1'b0, 1'b0, '0},
         '{7'd64,  1'b0, 1'b0, 1'b0, '0},
         '{7'd59,  1'b1, 1'b0, 1'b0, '0}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      fork
         receive_results();
      join_none

      foreach (directed_notes[i]) begin
         push_note(directed_notes[i].pitch, directed_notes[i].chord_end,
                   directed_notes[i].song_start, directed_notes[i].typed,
                   directed_notes[i].result);
      end

      for (int unsigned ph = 0; ph < 10; ph++) begin
         drain();
         len_word = random_word();
         steady   = 1'b0;
         case (ph)
            0: begin
               // widen mid-song so the start index wraps
               len_word[cisof_pkg::LEN_W-1:0] = 5'd16;
               steps_word = '0;
               cont = 1'b1;
            end
            1: begin
               len_word[cisof_pkg::LEN_W-1:0] = 5'd0;
               steps_word = random_steps();
               cont = 1'b0;
            end
            2: begin
               len_word[cisof_pkg::LEN_W-1:0] = 5'd1;
               steps_word = random_word();
               cont = 1'b1;
            end
            3: begin
               len_word   = '1;
               steps_word = '1;
               cont = 1'b0;
            end
            4: begin
               len_word[cisof_pkg::LEN_W-1:0] = 5'd17;
               steps_word = random_steps();
               cont = 1'b1;
            end
            5: begin
               len_word[cisof_pkg::LEN_W-1:0] = cisof_pkg::LEN_MIN;
               steps_word = random_steps();
               cont   = 1'b0;
               steady = 1'b1;
            end
            default: begin
               len_word[cisof_pkg::LEN_W-1:0] = cisof_pkg::LEN_W'($urandom_range(0, 31));
               steps_word = ($urandom_range(0, 3) != 0) ? random_steps() : random_word();
               cont   = 1'($urandom_range(0, 1));
               steady = (ph == 8);
            end
         endcase
         write_reg(cisof_pkg::CSR_LENGTH, len_word);
         write_reg(cisof_pkg::CSR_INTERVALS, steps_word);
         play_phase(80, cont);
      end

      drain();
      steady = 1'b0;
      repeat (10) @(posedge clock);
      if (errors == 0 && chord_results_due.size() == 0) begin
         $display("PASS chord_interval_shift_or_filter_core");
      end else begin
         $display("FAIL chord_interval_shift_or_filter_core");
      end
      $finish;
   end

endmodule
